// ===== rtl/bsre_pkg.sv =====
// Shared types and constants for the bitmap span run encoder.
package bsre_pkg;

    localparam int unsigned MAX_BEATS   = 4;   // bytes one pixel can cause
    localparam int unsigned QUEUE_DEPTH = 8;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QLVL_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned BCNT_W      = $clog2(MAX_BEATS + 1);

    localparam logic [3:0] SIZE_RESET   = 4'd11;
    localparam logic [3:0] MIN_SIZE     = 4'd9;
    localparam logic [3:0] MAX_RUN      = 4'd7;
    localparam logic [2:0] MAX_RUN_LEN  = 3'd7;
    localparam logic [7:0] END_BYTE     = 8'h00;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } t_beat;

    typedef struct packed {
        logic [BCNT_W-1:0]          count;
        t_beat [MAX_BEATS-1:0]      beats;
    } t_burst;

    typedef struct packed {
        logic [QLVL_W-1:0] level;
        logic              room;   // space for a whole burst
    } t_qstat;

endpackage

// ===== rtl/bitmap_span_run_encoder.sv =====
// Top level of the bitmap span run encoder: pixel in, code bytes out.
// With the byte queue empty, a pixel's first byte is out the cycle after it is taken.
// Throughput: one pixel a cycle while the 8-entry byte queue has room for four bytes;
//   bytes leave at one a cycle when i_ready is high, so long code bursts set the pace.
// Reset (synchronous, active low): icon size 11, scan position at row 0 column 0,
//   byte queue empty.
module bitmap_span_run_encoder import bsre_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration: icon size
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [3:0] i_cfg_data,
    // pixel beats
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_pixel_set,
    // code byte beats
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_code_byte,
    output logic       o_last_of_run
);

    t_burst burst;
    t_beat  head;
    t_qstat qstat;
    logic   pix_acc, byte_acc;

    // Size register is always writable; it is to be changed only while idle, which the user must ensure.
    assign o_cfg_ready = 1'b1;

    // A pixel is taken only when the queue can swallow its worst-case burst.
    assign o_ready  = qstat.room;
    assign pix_acc  = i_valid && o_ready;
    assign byte_acc = o_valid && i_ready;

    // Run detection, row/icon tracking and byte assembly for the current pixel.
    bsre_step u_step (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wr   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .i_accept   (pix_acc),
        .i_pixel_set(i_pixel_set),
        .o_burst    (burst)
    );

    // Output queue decouples bursts of up to four bytes from the byte stream.
    bsre_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (pix_acc),
        .i_burst(burst),
        .i_pop  (byte_acc),
        .o_valid(o_valid),
        .o_beat (head),
        .o_stat (qstat)
    );

    assign o_code_byte   = head.code;
    assign o_last_of_run = head.last;

    // The queue never overfills.
    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        qstat.level <= QLVL_W'(QUEUE_DEPTH))
        else $error("byte queue overflow");

    // A full queue must hold off pixels.
    a_full_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (qstat.level == QLVL_W'(QUEUE_DEPTH)) |-> !o_ready)
        else $error("pixel accepted with queue full");

    // Every non-empty burst marks its final byte.
    a_last_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pix_acc && burst.count != '0) |-> burst.beats[burst.count[1:0] - 2'd1].last)
        else $error("burst without final marker");

    // Burst size stays within the worst case.
    a_burst_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pix_acc |-> (burst.count <= BCNT_W'(MAX_BEATS)))
        else $error("burst too long");

endmodule

// ===== rtl/bsre_step.sv =====
// Per-pixel encoder: scan position state and the bytes one pixel causes.
module bsre_step import bsre_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr,
    input  logic [3:0] i_cfg_data,
    input  logic       i_accept,
    input  logic       i_pixel_set,
    output t_burst     o_burst
);

    logic [3:0] r_size, r_col, r_start, r_row, r_last;
    logic [3:0] n_col, n_start, n_row, n_last;

    logic [3:0] w, diff, dy, s1;
    logic [4:0] x1, s2, len_c;
    logic       full, run_b, run_c, run1, run2, row_end, icon_end, flag, skip;
    logic [2:0] len1;
    t_beat      cand [MAX_BEATS];
    logic [MAX_BEATS-1:0] cand_v;
    logic [BCNT_W-1:0]    n_beats;

    always_comb begin
        w        = (r_size < MIN_SIZE) ? MIN_SIZE : r_size;
        x1       = {1'b0, r_col} + 5'd1;
        diff     = r_col - r_start;
        full     = (diff == MAX_RUN);
        s1       = full ? r_col : r_start;
        run_b    = !i_pixel_set && !full && (r_col > r_start);
        s2       = i_pixel_set ? {1'b0, s1} : x1;
        row_end  = (x1 >= {1'b0, w});
        icon_end = row_end && (({1'b0, r_row} + 5'd1) >= {1'b0, w});
        run_c    = row_end && (x1 > s2);
        len_c    = x1 - s2;
        run1     = full || run_b || run_c;
        run2     = full && run_c;       // one-pixel tail after a full run
        len1     = full ? MAX_RUN_LEN : (run_b ? diff[2:0] : len_c[2:0]);
        dy       = r_row - r_last;
        flag     = (dy == 4'd1);
        skip     = (dy != 4'd0) && !flag;

        cand[0] = '{code: {4'h0, dy}, last: 1'b0};
        cand[1] = '{code: {flag, len1, r_start}, last: 1'b0};
        cand[2] = '{code: {1'b0, 3'd1, r_col}, last: 1'b0};
        cand[3] = '{code: END_BYTE, last: 1'b0};
        cand_v  = {icon_end, run2, run1, run1 && skip};

        // pack the present bytes into the low slots
        n_beats = '0;
        o_burst = '0;
        for (int k = 0; k < MAX_BEATS; k++) begin
            if (cand_v[k]) begin
                o_burst.beats[n_beats[1:0]] = cand[k];
                n_beats = n_beats + 1'b1;
            end
        end
        if (n_beats != '0) begin
            o_burst.beats[n_beats[1:0] - 2'd1].last = 1'b1;
        end
        o_burst.count = n_beats;

        // next scan position
        n_col   = row_end ? 4'd0 : x1[3:0];
        n_start = row_end ? 4'd0 : s2[3:0];
        n_row   = icon_end ? 4'd0 : (row_end ? r_row + 4'd1 : r_row);
        n_last  = icon_end ? 4'd0 : (run1 ? r_row : r_last);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size  <= SIZE_RESET;
            r_col   <= '0;
            r_start <= '0;
            r_row   <= '0;
            r_last  <= '0;
        end else begin
            if (i_cfg_wr) begin
                r_size <= i_cfg_data;
            end
            if (i_accept) begin
                r_col   <= n_col;
                r_start <= n_start;
                r_row   <= n_row;
                r_last  <= n_last;
            end
        end
    end

endmodule

// ===== rtl/bsre_queue.sv =====
// Byte queue: takes a burst of up to four beats, hands out one a cycle while i_pop is high.
module bsre_queue import bsre_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_burst     i_burst,
    input  logic       i_pop,
    output logic       o_valid,
    output t_beat      o_beat,
    output t_qstat     o_stat
);

    t_beat             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QLVL_W-1:0] r_level;
    logic [BCNT_W-1:0] push_n;
    logic [QPTR_W-1:0] offs [QUEUE_DEPTH];

    assign push_n = i_push ? i_burst.count : '0;
    assign o_valid = (r_level != '0);
    assign o_beat  = r_mem[r_rd];
    assign o_stat.level = r_level;
    assign o_stat.room  = (r_level <= QLVL_W'(QUEUE_DEPTH - MAX_BEATS));

    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            offs[i] = QPTR_W'(i) - r_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if ({1'b0, offs[i]} < (QPTR_W+1)'(push_n)) begin
                r_mem[i] <= i_burst.beats[offs[i][1:0]];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_level <= '0;
        end else begin
            r_wr    <= r_wr + QPTR_W'(push_n);
            r_rd    <= r_rd + QPTR_W'(i_pop);
            r_level <= r_level + QLVL_W'(push_n) - QLVL_W'(i_pop);
        end
    end

endmodule

// ===== sim/bitmap_span_run_encoder_checker.sv =====
// Checker for the span run encoder: predicts code bytes from pixel beats and compares them.
`timescale 1ns / 100ps
module bitmap_span_run_encoder_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [3:0]  i_cfg_data,
    input  logic        i_pix_valid,
    input  logic        i_pix_ready,
    input  logic        i_pixel_set,
    input  logic        i_code_valid,
    input  logic        i_code_ready,
    input  logic [7:0]  i_code_byte,
    input  logic        i_code_last,
    output int unsigned o_failures,
    output int unsigned o_pending,
    output int unsigned o_pixels,
    output int unsigned o_bytes
);

    localparam int unsigned RUN_CAP       = 7;
    localparam int unsigned ROW_STEP_FLAG = 8;
    localparam int unsigned SMALLEST_SIZE = 9;
    localparam logic [7:0]  ICON_END      = 8'h00;
    localparam logic [3:0]  SIZE_AT_RESET = 4'd11;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } t_code_beat;

    t_code_beat  expected_codes[$];
    logic [3:0]  icon_size_q;
    logic [3:0]  col_q;
    logic [3:0]  span_start_q;
    logic [3:0]  row_q;
    logic [3:0]  last_row_q;
    int unsigned failures;
    int unsigned pixels;
    int unsigned bytes;

    // queue one span byte, preceded by a row skip where the gap is two rows or more
    function automatic void queue_span(input int unsigned len, input int unsigned row);
        int unsigned dy;
        t_code_beat  b;
        dy = row - last_row_q;
        if (dy != 0) begin
            if (dy == 1) begin
                len = len | ROW_STEP_FLAG;
            end else begin
                b.code = {4'd0, 4'(dy)};
                b.last = 1'b0;
                expected_codes.push_back(b);
            end
            last_row_q = 4'(row);
        end
        b.code = {4'(len), span_start_q};
        b.last = 1'b0;
        expected_codes.push_back(b);
    endfunction

    function automatic void predict_pixel(input logic pix);
        int unsigned w;
        int unsigned x;
        int unsigned y;
        int unsigned n0;
        w  = (icon_size_q < SMALLEST_SIZE) ? SMALLEST_SIZE : icon_size_q;
        x  = col_q;
        y  = row_q;
        n0 = expected_codes.size();
        // full span closed before this pixel counts
        if (x - span_start_q == RUN_CAP) begin
            queue_span(RUN_CAP, y);
            span_start_q = 4'(x);
        end
        if (!pix) begin
            if (x > span_start_q)
                queue_span(x - span_start_q, y);
            span_start_q = 4'(x + 1);
        end
        if (x + 1 >= w) begin
            if (x + 1 > span_start_q)
                queue_span(x + 1 - span_start_q, y);
            col_q        = 4'd0;
            span_start_q = 4'd0;
            if (y + 1 >= w) begin
                expected_codes.push_back('{code: ICON_END, last: 1'b0});
                row_q      = 4'd0;
                last_row_q = 4'd0;
            end else begin
                row_q = 4'(y + 1);
            end
        end else begin
            col_q = 4'(x + 1);
        end
        if (expected_codes.size() > n0)
            expected_codes[expected_codes.size() - 1].last = 1'b1;
    endfunction

    always @(posedge i_clk) begin : watch
        t_code_beat want;
        if (!i_rst_n) begin
            expected_codes.delete();
            icon_size_q  = SIZE_AT_RESET;
            col_q        = 4'd0;
            span_start_q = 4'd0;
            row_q        = 4'd0;
            last_row_q   = 4'd0;
        end else begin
            if (i_code_valid && i_code_ready) begin
                bytes++;
                if (expected_codes.size() == 0) begin
                    failures++;
                    if (failures <= 10)
                        $display("%0t: unexpected code byte %02h last %0b",
                                 $realtime, i_code_byte, i_code_last);
                end else begin
                    want = expected_codes.pop_front();
                    if (want.code !== i_code_byte || want.last !== i_code_last) begin
                        failures++;
                        if (failures <= 10)
                            $display("%0t: byte %0d expected %02h last %0b, got %02h last %0b",
                                     $realtime, bytes, want.code, want.last,
                                     i_code_byte, i_code_last);
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                icon_size_q = i_cfg_data;
            if (i_pix_valid && i_pix_ready) begin
                predict_pixel(i_pixel_set);
                pixels++;
            end
        end
        o_failures <= failures;
        o_pending  <= expected_codes.size();
        o_pixels   <= pixels;
        o_bytes    <= bytes;
    end

endmodule

// ===== sim/bitmap_span_run_encoder_tb.sv =====
// Testbench top for the span run encoder: stimulus, idling, timeout and verdict.
`timescale 1ns / 100ps
module bitmap_span_run_encoder_tb;

    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned SETTLE_CYCLES = 8;     // idle margin after the last predicted byte

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [3:0]  i_cfg_data  = 4'd0;
    logic        i_valid     = 1'b0;
    logic        i_pixel_set = 1'b0;
    logic        i_ready     = 1'b0;
    logic        o_cfg_ready;
    logic        o_ready;
    logic        o_valid;
    logic [7:0]  o_code_byte;
    logic        o_last_of_run;

    int unsigned tx_idle_pct = 0;   // chance in a hundred that the pixel side holds off
    int unsigned rx_idle_pct = 0;   // chance in a hundred that the byte side stalls
    int unsigned cycle_count = 0;
    int unsigned failures;
    int unsigned pending;
    int unsigned pixels;
    int unsigned bytes;
    logic [15:0] sizes_written = '0;
    int unsigned size_kinds    = 0;

    bitmap_span_run_encoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_pixel_set   (i_pixel_set),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_code_byte   (o_code_byte),
        .o_last_of_run (o_last_of_run)
    );

    bitmap_span_run_encoder_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_pix_valid  (i_valid),
        .i_pix_ready  (o_ready),
        .i_pixel_set  (i_pixel_set),
        .i_code_valid (o_valid),
        .i_code_ready (i_ready),
        .i_code_byte  (o_code_byte),
        .i_code_last  (o_last_of_run),
        .o_failures   (failures),
        .o_pending    (pending),
        .o_pixels     (pixels),
        .o_bytes      (bytes)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Byte side: stalls drawn fresh every cycle, so they can land on any phase of a burst.
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("bitmap_span_run_encoder regression: fail");
            $finish;
        end
    end

    // One pixel beat. Valid is only ever set once per step: low while holding off,
    // high from the first offer until the beat goes through.
    task automatic send_pixel(input logic pix);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_pixel_set <= pix;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // Hold the pixel side off until every predicted byte has come out, then let
    // the pipe settle, since a pixel with no bytes may still be in flight.
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Size writes only ever land on an idle block, though often part-way through an icon.
    task automatic write_size(input logic [3:0] value);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (!sizes_written[value]) size_kinds++;
        sizes_written[value] = 1'b1;
    endtask

    initial begin
        int unsigned burst;
        int unsigned density;
        int unsigned part;
        logic [3:0]  size_pick;

        density = 50;
        part    = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed, at the reset size of 11.
        // Row 0 fully set: a span of 7 is cut off, the rest flushed at the row end.
        repeat (11) send_pixel(1'b1);
        // Row 1: a lone pixel one row down, then a long stretch up to column 9.
        send_pixel(1'b0);
        send_pixel(1'b1);
        send_pixel(1'b0);
        repeat (7) send_pixel(1'b1);
        // Shrink to 9 while at column 10: the next pixel closes a full span and
        // ends the row on its own.
        write_size(4'd9);
        send_pixel(1'b1);
        // Size below the minimum, taken as 9; the random part starts from here.
        write_size(4'd0);

        // Random: sender idle 10 / receiver 71, then swapped, then no idling at all.
        for (int mode = 0; mode < 3; mode++) begin
            tx_idle_pct = (mode == 0) ? 10 : (mode == 1) ? 71 : 0;
            rx_idle_pct = (mode == 0) ? 71 : (mode == 1) ? 10 : 0;
            for (int k = 0; k < 2; k++) begin
                // extremes first, then anything the 4-bit field holds
                size_pick = (part == 0) ? 4'd8 : (part == 1) ? 4'd15 : 4'($urandom_range(15));
                part++;
                write_size(size_pick);
                burst = $urandom_range(40, 80);
                repeat (burst) begin
                    // pixel density drifts: blank rows give row skips, dense ones long spans
                    if ($urandom_range(7) == 0)
                        case ($urandom_range(4))
                            0: density = 0;
                            1: density = 15;
                            2: density = 50;
                            3: density = 85;
                            default: density = 100;
                        endcase
                    send_pixel($urandom_range(99) < density);
                end
            end
        end

        wait_drained();
        $display("run covered %0d pixels and %0d code bytes over %0d icon size values",
                 pixels, bytes, size_kinds);
        $display("idling mixes: sender-light, receiver-light and none; size changes mid-icon");
        if (failures == 0 && pending == 0) begin
            $display("bitmap_span_run_encoder regression: pass");
        end else begin
            $display("bitmap_span_run_encoder regression: fail");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/bsre_pkg.sv
rtl/bsre_step.sv
rtl/bsre_queue.sv
rtl/bitmap_span_run_encoder.sv
sim/bitmap_span_run_encoder_checker.sv
sim/bitmap_span_run_encoder_tb.sv
